@@ rtl/oomsched_pkg.sv @@
// shared types, constants and path tables of the motor scheduler
package oomsched_pkg;

	localparam int PATH_MAX    = 16;
	localparam int MOTOR_COUNT = 9;
	localparam int TIME_BITS   = 20;
	localparam int DIGITS      = 10;

	localparam int PATH_IDX_W = $clog2(PATH_MAX);
	localparam int STEP_W     = 5;
	localparam int CELL_W     = 4;
	localparam int DIGIT_W    = 4;
	localparam int PULSE_W    = 12;
	localparam int LEVEL_W    = 7;
	localparam int HOLD16_W   = 8;
	localparam int SOA_W      = 11;
	localparam int EXTRA_W    = 16;
	localparam int HOLD_W     = 16;
	localparam int ONSET_W    = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [TIME_BITS-1:0] TIME_TOP  = {TIME_BITS{1'b1}};
	localparam logic [DIGIT_W-1:0]   DIGIT_TOP = DIGIT_W'(DIGITS - 1);
	localparam logic [HOLD16_W-1:0]  UNIT_HOLD = HOLD16_W'(16);

	// operation codes of a request
	typedef enum logic {
		OP_START = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	// register indexes of the write port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SETTINGS_VALID = 3'd0,
		CFG_PULSE_MS       = 3'd1,
		CFG_DRIVE_LEVEL    = 3'd2,
		CFG_FIRST_HOLD     = 3'd3,
		CFG_LAST_HOLD      = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic               operation;
		logic [DIGIT_W-1:0] digit_value;
	} in_item_t;

	typedef struct packed {
		logic [MOTOR_COUNT-1:0] motor_mask;
		logic [LEVEL_W-1:0]     motor_level;
		logic                   playing;
		logic                   finished;
	} out_item_t;

	// live settings plus values derived from them at write time
	typedef struct packed {
		logic [PULSE_W-1:0]  pulse_ms;
		logic [LEVEL_W-1:0]  drive_level;
		logic [HOLD16_W-1:0] first_hold;
		logic [HOLD16_W-1:0] last_hold;
		logic [SOA_W-1:0]    soa;
		logic [EXTRA_W-1:0]  extra;
	} cfg_t;

	// playback state of one digit
	typedef struct packed {
		logic [TIME_BITS-1:0]                  elapsed;
		logic [MOTOR_COUNT-1:0][TIME_BITS-1:0] deadline;
		logic [STEP_W-1:0]                     next_step;
		logic [DIGIT_W-1:0]                    digit;
	} play_state_t;

	localparam logic [STEP_W-1:0] PATH_LEN [DIGITS] = '{
		5'd9, 5'd3, 5'd9, 5'd9, 5'd7, 5'd9, 5'd10, 5'd5, 5'd13, 5'd11
	};

	localparam logic [CELL_W-1:0] PATH_CELLS [DIGITS][PATH_MAX] = '{
		'{4'd0, 4'd1, 4'd2, 4'd5, 4'd8, 4'd7, 4'd6, 4'd3,
		  4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd1, 4'd4, 4'd7, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
		  4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd0, 4'd1, 4'd2, 4'd5, 4'd4, 4'd3, 4'd6, 4'd7,
		  4'd8, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd0, 4'd1, 4'd2, 4'd5, 4'd4, 4'd5, 4'd8, 4'd7,
		  4'd6, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd0, 4'd3, 4'd4, 4'd5, 4'd1, 4'd4, 4'd7, 4'd0,
		  4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd2, 4'd1, 4'd0, 4'd3, 4'd4, 4'd5, 4'd8, 4'd7,
		  4'd6, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd2, 4'd1, 4'd0, 4'd3, 4'd6, 4'd7, 4'd8, 4'd5,
		  4'd4, 4'd3, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd0, 4'd1, 4'd2, 4'd5, 4'd8, 4'd0, 4'd0, 4'd0,
		  4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd1, 4'd0, 4'd3, 4'd4, 4'd5, 4'd8, 4'd7, 4'd6,
		  4'd3, 4'd4, 4'd5, 4'd2, 4'd1, 4'd0, 4'd0, 4'd0},
		'{4'd2, 4'd1, 4'd0, 4'd3, 4'd4, 4'd5, 4'd2, 4'd5,
		  4'd8, 4'd7, 4'd6, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
	};

	// number of steps in the path of a digit
	function automatic logic [STEP_W-1:0] path_len(input logic [DIGIT_W-1:0] digit);
		path_len = PATH_LEN[digit];
	endfunction

	// motor of one path step
	function automatic logic [CELL_W-1:0] path_cell(input logic [DIGIT_W-1:0] digit,
			input logic [STEP_W-1:0] step);
		path_cell = PATH_CELLS[digit][step[PATH_IDX_W-1:0]];
	endfunction

endpackage

@@ rtl/oomsched_eval.sv @@
// one tick of playback: onset check, motor deadlines and result
module oomsched_eval (
	input  oomsched_pkg::cfg_t        cfg,
	input  oomsched_pkg::play_state_t cur,
	output oomsched_pkg::play_state_t nxt,
	output oomsched_pkg::out_item_t   res
);

	localparam int PROD_W = oomsched_pkg::PULSE_W + oomsched_pkg::HOLD16_W;

	logic [oomsched_pkg::TIME_BITS-1:0]   t;
	logic [oomsched_pkg::STEP_W-1:0]      len;
	logic [oomsched_pkg::STEP_W-1:0]      step;
	logic                                 any_old;
	logic                                 fire;
	logic [oomsched_pkg::ONSET_W-1:0]     onset;
	logic [oomsched_pkg::ONSET_W-1:0]     soa_mul;
	logic [oomsched_pkg::HOLD16_W-1:0]    factor;
	logic [PROD_W-1:0]                    hold_prod;
	logic [oomsched_pkg::HOLD_W-1:0]      hold;
	logic [oomsched_pkg::TIME_BITS:0]     due_sum;
	logic [oomsched_pkg::TIME_BITS-1:0]   due;
	logic [oomsched_pkg::CELL_W-1:0]      motor_idx;
	logic [oomsched_pkg::STEP_W-1:0]      step_nxt;
	logic [oomsched_pkg::MOTOR_COUNT-1:0] mask;
	logic                                 fin;

	assign t         = cur.elapsed;
	assign step      = cur.next_step;
	assign len       = oomsched_pkg::path_len(cur.digit);
	assign motor_idx = oomsched_pkg::path_cell(cur.digit, step);

	// motors still running before this tick starts anything
	always_comb begin
		any_old = 1'b0;
		for (int i = 0; i < oomsched_pkg::MOTOR_COUNT; i++) begin
			if (t < cur.deadline[i]) begin
				any_old = 1'b1;
			end
		end
	end

	// onset of the pending step
	assign soa_mul = oomsched_pkg::ONSET_W'(step) * oomsched_pkg::ONSET_W'(cfg.soa);
	assign onset   = (step == '0) ? '0 : oomsched_pkg::ONSET_W'(cfg.extra) + soa_mul;
	assign fire    = (step < len) &&
		(t >= oomsched_pkg::TIME_BITS'(onset));

	// hold time of the pending step, saturated deadline
	always_comb begin
		if (step == '0) begin
			factor = cfg.first_hold;
		end else if (step == len - oomsched_pkg::STEP_W'(1)) begin
			factor = cfg.last_hold;
		end else begin
			factor = oomsched_pkg::UNIT_HOLD;
		end
	end

	assign hold_prod = PROD_W'(cfg.pulse_ms) * PROD_W'(factor);
	assign hold      = hold_prod[PROD_W-1:4];
	assign due_sum   = {1'b0, t} + (oomsched_pkg::TIME_BITS + 1)'(hold);
	assign due       = due_sum[oomsched_pkg::TIME_BITS] ?
		oomsched_pkg::TIME_TOP : due_sum[oomsched_pkg::TIME_BITS-1:0];

	// next state
	always_comb begin
		nxt = cur;
		if (fire) begin
			for (int i = 0; i < oomsched_pkg::MOTOR_COUNT; i++) begin
				if (motor_idx == oomsched_pkg::CELL_W'(i)) begin
					nxt.deadline[i] = due;
				end
			end
		end
		nxt.next_step = step_nxt;
		nxt.elapsed   = (t == oomsched_pkg::TIME_TOP) ? t :
			t + oomsched_pkg::TIME_BITS'(1);
	end

	assign step_nxt = fire ? step + oomsched_pkg::STEP_W'(1) : step;

	// mask after the update
	always_comb begin
		for (int i = 0; i < oomsched_pkg::MOTOR_COUNT; i++) begin
			mask[i] = t < nxt.deadline[i];
		end
	end

	assign fin = (step_nxt >= len) && !(any_old || fire);

	// result of the tick
	always_comb begin
		res.motor_mask  = mask;
		res.motor_level = (mask != '0) ? cfg.drive_level : '0;
		res.playing     = !fin;
		res.finished    = fin;
	end

endmodule

@@ rtl/overlapping_onset_motor_scheduler.sv @@
// top level of the apparent-motion digit player for a 3x3 motor grid
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------
//  in       | in_valid/in_ready  | in_data  (operation, digit_value)
//  out      | out_valid/out_ready| out_data (mask, level, playing, done)
//  cfg      | cfg_we             | cfg_index, cfg_wdata
//
// a request is taken into an input register, evaluated from there by the
// single tick evaluation stage and its result lands in the output register;
// one request per cycle is sustained while the output is not stalled.
// reset clears settings to their defaults and all playback state.
// a waiting result stalls evaluation only; the input register still takes
// a request whenever it is empty or drains in that cycle.
module overlapping_onset_motor_scheduler (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  oomsched_pkg::in_item_t               in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output oomsched_pkg::out_item_t              out_data,
	input  logic                                 cfg_we,
	input  logic [oomsched_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [oomsched_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int SOA_SUM_W = 19;
	localparam int EXTRA_P_W = oomsched_pkg::PULSE_W + oomsched_pkg::HOLD16_W;

	// onset spacing from the pulse length
	function automatic logic [oomsched_pkg::SOA_W-1:0] calc_soa(
			input logic [oomsched_pkg::PULSE_W-1:0] pulse);
		logic [SOA_SUM_W-1:0] s;
		s = SOA_SUM_W'(pulse) * SOA_SUM_W'(82) + SOA_SUM_W'(12109);
		calc_soa = s[SOA_SUM_W-1:8];
	endfunction

	// start extra delay from the first hold factor
	function automatic logic [oomsched_pkg::EXTRA_W-1:0] calc_extra(
			input logic [oomsched_pkg::HOLD16_W-1:0] first,
			input logic [oomsched_pkg::PULSE_W-1:0]  pulse);
		logic [EXTRA_P_W-1:0] p;
		p = EXTRA_P_W'(first - oomsched_pkg::UNIT_HOLD) * EXTRA_P_W'(pulse);
		calc_extra = (first > oomsched_pkg::UNIT_HOLD) ? p[EXTRA_P_W-1:4] : '0;
	endfunction

	logic                        settings_valid_q;
	oomsched_pkg::cfg_t          cfg_q;
	oomsched_pkg::play_state_t   state_q;
	oomsched_pkg::play_state_t   state_nxt;
	oomsched_pkg::out_item_t     tick_res;
	logic                        busy_q;
	logic                        valid_s1;
	oomsched_pkg::in_item_t      req_s1;
	logic                        out_valid_q;
	oomsched_pkg::out_item_t     out_data_q;
	logic                        advance;
	logic                        start_ok;
	logic [oomsched_pkg::DIGIT_W-1:0] digit_clamped;

	// settings registers with derived timing values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settings_valid_q <= 1'b0;
			cfg_q.pulse_ms   <= '0;
			cfg_q.drive_level <= '0;
			cfg_q.first_hold <= oomsched_pkg::UNIT_HOLD;
			cfg_q.last_hold  <= oomsched_pkg::UNIT_HOLD;
			cfg_q.soa        <= calc_soa('0);
			cfg_q.extra      <= '0;
		end else if (cfg_we) begin
			case (oomsched_pkg::cfg_index_t'(cfg_index))
				oomsched_pkg::CFG_SETTINGS_VALID: begin
					settings_valid_q <= cfg_wdata[0];
				end
				oomsched_pkg::CFG_PULSE_MS: begin
					cfg_q.pulse_ms <= cfg_wdata;
					cfg_q.soa      <= calc_soa(cfg_wdata);
					cfg_q.extra    <= calc_extra(cfg_q.first_hold, cfg_wdata);
				end
				oomsched_pkg::CFG_DRIVE_LEVEL: begin
					cfg_q.drive_level <= cfg_wdata[oomsched_pkg::LEVEL_W-1:0];
				end
				oomsched_pkg::CFG_FIRST_HOLD: begin
					cfg_q.first_hold <= cfg_wdata[oomsched_pkg::HOLD16_W-1:0];
					cfg_q.extra <= calc_extra(cfg_wdata[oomsched_pkg::HOLD16_W-1:0],
						cfg_q.pulse_ms);
				end
				oomsched_pkg::CFG_LAST_HOLD: begin
					cfg_q.last_hold <= cfg_wdata[oomsched_pkg::HOLD16_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// handshake between input register and output register
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= in_data;
		end
	end

	oomsched_eval u_eval (
		.cfg (cfg_q),
		.cur (state_q),
		.nxt (state_nxt),
		.res (tick_res)
	);

	assign start_ok = settings_valid_q && (cfg_q.pulse_ms != '0) &&
		(cfg_q.drive_level != '0);
	assign digit_clamped = (req_s1.digit_value > oomsched_pkg::DIGIT_TOP) ?
		oomsched_pkg::DIGIT_TOP : req_s1.digit_value;

	// playback state, updated at most once per evaluated request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			busy_q  <= 1'b0;
		end else if (advance) begin
			if (oomsched_pkg::op_t'(req_s1.operation) == oomsched_pkg::OP_START) begin
				state_q.elapsed   <= '0;
				state_q.deadline  <= '0;
				state_q.next_step <= '0;
				state_q.digit     <= digit_clamped;
				busy_q            <= start_ok;
			end else if (busy_q) begin
				state_q <= state_nxt;
				busy_q  <= !tick_res.finished;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if ((oomsched_pkg::op_t'(req_s1.operation) == oomsched_pkg::OP_TICK) &&
					busy_q) begin
				out_data_q <= tick_res;
			end else begin
				out_data_q <= '0;
			end
		end
	end

	// checks
	a_fin_not_playing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.finished && out_data.playing))
		else $error("finished result still reports playing");

	a_level_needs_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.motor_mask == '0)) |-> (out_data.motor_level == '0))
		else $error("drive level reported with no motor on");

	a_step_in_path: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.next_step <= oomsched_pkg::path_len(state_q.digit))
		else $error("path step beyond path length");

	a_time_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q.elapsed))
		else $error("playback time moved without a request");

endmodule
